@@ rtl/text_window_console_macros.svh @@
// assertion macros for the text window console
`ifndef TEXT_WINDOW_CONSOLE_MACROS_SVH
`define TEXT_WINDOW_CONSOLE_MACROS_SVH

// condition holds at every edge out of reset
`define TWC_ASSERT_NOW(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define TWC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define TWC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/twc_pkg.sv @@
// shared types and constants of the text window console
package twc_pkg;

    localparam int OFFSET_W  = 11;
    localparam int ROW_CFG_W = 5;
    localparam int PADDR_W   = 4;

    typedef logic [1:0]          opcode_t;
    typedef logic [1:0]          reg_index_t;
    typedef logic [OFFSET_W-1:0] offset_t;

    localparam opcode_t OP_PUT       = 2'd0;
    localparam opcode_t OP_BACKSPACE = 2'd1;
    localparam opcode_t OP_CLEAR     = 2'd2;
    localparam opcode_t OP_READ      = 2'd3;

    localparam reg_index_t REG_FIRST_ROW = 2'd0;
    localparam reg_index_t REG_LAST_ROW  = 2'd1;
    localparam reg_index_t REG_INK_COLOR = 2'd2;

    localparam logic [7:0]           BLANK_CHAR      = 8'd32;
    localparam logic [7:0]           NEWLINE_CHAR    = 8'd10;
    localparam logic [7:0]           ATTR_RESET      = 8'd15;
    localparam logic [ROW_CFG_W-1:0] FIRST_ROW_RESET = 5'd0;
    localparam logic [ROW_CFG_W-1:0] LAST_ROW_RESET  = 5'd24;
    localparam logic [7:0]           INK_COLOR_RESET = 8'd15;

    typedef struct packed {
        opcode_t              opcode;
        logic [7:0]           char_code;
        logic [ROW_CFG_W-1:0] cell_row;
        logic [6:0]           cell_col;
    } req_t;

    typedef struct packed {
        offset_t    cursor_offset;
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
    } rsp_t;

endpackage

@@ rtl/text_window_console.sv @@
// text window console: character and attribute memories, cursor control and register port
// put, newline, backspace and read: done is registered from ST_EXEC, next request accepted with done
// a put or newline at the window end scrolls first, one cell per cycle, then returns to ST_EXEC
// clear blanks the window cells in turn, limited by the single memory write port
// after reset a clearing pass writes all SCREEN_ROWS*SCREEN_COLS cells with busy high
// done is a one-cycle strobe; the receiver cannot stall

`include "text_window_console_macros.svh"

module text_window_console #(
    parameter int SCREEN_ROWS = 25,
    parameter int SCREEN_COLS = 80
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  twc_pkg::req_t                req,
    output logic                         busy,
    output logic                         done,
    output twc_pkg::rsp_t                rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [twc_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int CELL_COUNT = SCREEN_ROWS * SCREEN_COLS;
    localparam int MEM_AW     = $clog2(CELL_COUNT);
    localparam int ADDR_W     = $clog2(CELL_COUNT + 1);
    localparam int COL_W      = $clog2(SCREEN_COLS);
    localparam int ROW_W      = ($clog2(SCREEN_ROWS + 1) > twc_pkg::ROW_CFG_W) ?
                                $clog2(SCREEN_ROWS + 1) : twc_pkg::ROW_CFG_W;
    localparam int CC_W       = ($clog2(SCREEN_COLS + 1) > 7) ? $clog2(SCREEN_COLS + 1) : 7;

    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(SCREEN_COLS);
    localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ROW_W-1:0]  ROW_MAX   = ROW_W'(SCREEN_ROWS - 1);
    localparam logic [ROW_W-1:0]  ROWS_R    = ROW_W'(SCREEN_ROWS);
    localparam logic [CC_W-1:0]   COLS_C    = CC_W'(SCREEN_COLS);
    localparam logic [COL_W-1:0]  COL_MAX   = COL_W'(SCREEN_COLS - 1);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_SCROLL_END,
        ST_CLEAR
    } state_t;

    function automatic logic [ROW_W-1:0] sat_row(input logic [twc_pkg::ROW_CFG_W-1:0] r);
        logic [ROW_W-1:0] rw;
        rw = ROW_W'(r);
        if (rw > ROW_MAX)
        begin
            rw = ROW_MAX;
        end
        return rw;
    endfunction

    function automatic logic [ADDR_W-1:0] row_base(input logic [ROW_W-1:0] r);
        return ADDR_W'(r * SCREEN_COLS);
    endfunction

    // configuration registers
    logic [twc_pkg::ROW_CFG_W-1:0] first_row_reg;
    logic [twc_pkg::ROW_CFG_W-1:0] last_row_reg;
    logic [7:0]                    ink_color_reg;

    // control and datapath registers
    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   cursor_reg, cursor_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ADDR_W-1:0]   ptr_reg, ptr_next;
    twc_pkg::req_t       req_reg, req_next;
    logic                rd_ok_reg, rd_ok_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [ADDR_W-1:0]   pend_addr_reg, pend_addr_next;
    logic                pend_blank_reg, pend_blank_next;
    logic                done_reg, done_next;
    twc_pkg::rsp_t       rsp_reg, rsp_next;

    // window bounds
    logic [ROW_W-1:0]    fr_sat;
    logic [ROW_W-1:0]    lr_sat;
    logic [ADDR_W-1:0]   win_start;
    logic [ADDR_W-1:0]   win_end;
    logic [ADDR_W-1:0]   win_last;
    logic [ADDR_W-1:0]   win_tail;

    // register port
    logic                cfg_we;
    twc_pkg::reg_index_t cfg_index;

    // memory ports
    logic                dir_we;
    logic                dir_attr_we;
    logic [ADDR_W-1:0]   dir_addr;
    logic [7:0]          dir_char;
    logic [7:0]          dir_attr;
    logic                char_we;
    logic                attr_we;
    logic [ADDR_W-1:0]   wr_addr;
    logic [7:0]          char_wdata;
    logic [7:0]          attr_wdata;
    logic [ADDR_W-1:0]   rd_addr;
    logic [7:0]          char_rdata_reg;
    logic [7:0]          attr_rdata_reg;
    logic [7:0]          char_mem [CELL_COUNT];
    logic [7:0]          attr_mem [CELL_COUNT];

    logic                req_in_range;
    logic [ADDR_W-1:0]   req_idx;
    logic                finish;

    always_comb
    begin
        fr_sat = sat_row(first_row_reg);
        lr_sat = sat_row(last_row_reg);
        if (lr_sat < fr_sat)
        begin
            lr_sat = fr_sat;
        end
    end

    assign win_start = row_base(fr_sat);
    assign win_end   = row_base(ROW_W'(lr_sat + 1'b1));
    assign win_last  = win_end - COLS_A;
    assign win_tail  = win_end - 1'b1;

    assign cfg_we    = psel && penable && pwrite;
    assign cfg_index = paddr[3:2];
    assign pready    = 1'b1;

    always_comb
    begin
        prdata = '0;
        case (cfg_index)
            twc_pkg::REG_FIRST_ROW: prdata = 32'(first_row_reg);
            twc_pkg::REG_LAST_ROW:  prdata = 32'(last_row_reg);
            twc_pkg::REG_INK_COLOR: prdata = 32'(ink_color_reg);
            default:                prdata = '0;
        endcase
    end

    assign req_in_range = (ROW_W'(req.cell_row) < ROWS_R) && (CC_W'(req.cell_col) < COLS_C);
    assign req_idx      = row_base(ROW_W'(req.cell_row)) + ADDR_W'(req.cell_col);

    // read address: row below during a scroll copy, else the requested cell (zero when out of range)
    always_comb
    begin
        if (state_reg == ST_SCROLL && ptr_reg < win_last)
        begin
            rd_addr = ptr_reg + COLS_A;
        end
        else if (req_in_range)
        begin
            rd_addr = req_idx;
        end
        else
        begin
            rd_addr = '0;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cursor_next     = cursor_reg;
        col_next        = col_reg;
        ptr_next        = ptr_reg;
        req_next        = req_reg;
        rd_ok_next      = rd_ok_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = pend_addr_reg;
        pend_blank_next = pend_blank_reg;
        done_next       = 1'b0;
        rsp_next        = rsp_reg;
        dir_we          = 1'b0;
        dir_attr_we     = 1'b0;
        dir_addr        = ptr_reg;
        dir_char        = twc_pkg::BLANK_CHAR;
        dir_attr        = ink_color_reg;
        finish          = 1'b0;

        unique case (state_reg)
            ST_INIT:
            begin
                dir_we      = 1'b1;
                dir_attr_we = 1'b1;
                dir_attr    = twc_pkg::ATTR_RESET;
                if (ptr_reg == CELL_LAST)
                begin
                    ptr_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next   = req;
                    rd_ok_next = req_in_range;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (req_reg.opcode)
                    twc_pkg::OP_PUT:
                    begin
                        if (cursor_reg == win_end)
                        begin
                            ptr_next   = win_start;
                            state_next = ST_SCROLL;
                        end
                        else if (req_reg.char_code == twc_pkg::NEWLINE_CHAR)
                        begin
                            cursor_next = cursor_reg + COLS_A - ADDR_W'(col_reg);
                            col_next    = '0;
                            finish      = 1'b1;
                        end
                        else
                        begin
                            dir_we      = 1'b1;
                            dir_attr_we = 1'b1;
                            dir_addr    = cursor_reg;
                            dir_char    = req_reg.char_code;
                            cursor_next = cursor_reg + 1'b1;
                            col_next    = (col_reg == COL_MAX) ? '0 : col_reg + 1'b1;
                            finish      = 1'b1;
                        end
                    end
                    twc_pkg::OP_BACKSPACE:
                    begin
                        if (cursor_reg != win_start)
                        begin
                            dir_we      = 1'b1;
                            dir_addr    = cursor_reg - 1'b1;
                            cursor_next = cursor_reg - 1'b1;
                            col_next    = (col_reg == '0) ? COL_MAX : col_reg - 1'b1;
                        end
                        finish = 1'b1;
                    end
                    twc_pkg::OP_CLEAR:
                    begin
                        ptr_next   = win_start;
                        state_next = ST_CLEAR;
                    end
                    twc_pkg::OP_READ:
                    begin
                        finish = 1'b1;
                    end
                endcase
            end
            ST_SCROLL:
            begin
                // copy rows up, then blank the last row; each write follows its read in the next cycle
                pend_valid_next = 1'b1;
                pend_addr_next  = ptr_reg;
                pend_blank_next = (ptr_reg >= win_last);
                if (ptr_reg == win_tail)
                begin
                    state_next = ST_SCROLL_END;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_SCROLL_END:
            begin
                cursor_next = cursor_reg - COLS_A;
                state_next  = ST_EXEC;
            end
            ST_CLEAR:
            begin
                dir_we      = 1'b1;
                dir_attr_we = 1'b1;
                if (ptr_reg == win_tail)
                begin
                    cursor_next = win_start;
                    col_next    = '0;
                    finish      = 1'b1;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (finish)
        begin
            done_next              = 1'b1;
            state_next             = ST_IDLE;
            rsp_next.cursor_offset = twc_pkg::offset_t'(cursor_next);
            if (state_reg == ST_EXEC && req_reg.opcode == twc_pkg::OP_READ && rd_ok_reg)
            begin
                rsp_next.cell_char = char_rdata_reg;
                rsp_next.cell_attr = attr_rdata_reg;
            end
            else
            begin
                rsp_next.cell_char = '0;
                rsp_next.cell_attr = '0;
            end
        end

        // window writes home the cursor
        if (cfg_we && cfg_index == twc_pkg::REG_FIRST_ROW)
        begin
            cursor_next = row_base(sat_row(pwdata[twc_pkg::ROW_CFG_W-1:0]));
            col_next    = '0;
        end
        else if (cfg_we && cfg_index == twc_pkg::REG_LAST_ROW)
        begin
            cursor_next = win_start;
            col_next    = '0;
        end
    end

    // write port: pending scroll write or a direct write, never both
    always_comb
    begin
        if (pend_valid_reg)
        begin
            char_we    = 1'b1;
            attr_we    = !pend_blank_reg;
            wr_addr    = pend_addr_reg;
            char_wdata = pend_blank_reg ? twc_pkg::BLANK_CHAR : char_rdata_reg;
            attr_wdata = ink_color_reg;
        end
        else
        begin
            char_we    = dir_we;
            attr_we    = dir_attr_we;
            wr_addr    = dir_addr;
            char_wdata = dir_char;
            attr_wdata = dir_attr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_we)
        begin
            char_mem[wr_addr[MEM_AW-1:0]] <= char_wdata;
        end
        char_rdata_reg <= char_mem[rd_addr[MEM_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (attr_we)
        begin
            attr_mem[wr_addr[MEM_AW-1:0]] <= attr_wdata;
        end
        attr_rdata_reg <= attr_mem[rd_addr[MEM_AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            cursor_reg     <= '0;
            col_reg        <= '0;
            ptr_reg        <= '0;
            req_reg        <= '0;
            rd_ok_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_addr_reg  <= '0;
            pend_blank_reg <= 1'b0;
            done_reg       <= 1'b0;
            rsp_reg        <= '0;
            first_row_reg  <= twc_pkg::FIRST_ROW_RESET;
            last_row_reg   <= twc_pkg::LAST_ROW_RESET;
            ink_color_reg  <= twc_pkg::INK_COLOR_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            cursor_reg     <= cursor_next;
            col_reg        <= col_next;
            ptr_reg        <= ptr_next;
            req_reg        <= req_next;
            rd_ok_reg      <= rd_ok_next;
            pend_valid_reg <= pend_valid_next;
            pend_addr_reg  <= pend_addr_next;
            pend_blank_reg <= pend_blank_next;
            done_reg       <= done_next;
            rsp_reg        <= rsp_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    twc_pkg::REG_FIRST_ROW: first_row_reg <= pwdata[twc_pkg::ROW_CFG_W-1:0];
                    twc_pkg::REG_LAST_ROW:  last_row_reg  <= pwdata[twc_pkg::ROW_CFG_W-1:0];
                    twc_pkg::REG_INK_COLOR: ink_color_reg <= pwdata[7:0];
                    default:                ink_color_reg <= ink_color_reg;
                endcase
            end
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    `TWC_ASSERT_IMP(a_cursor_in_window, state_reg == ST_IDLE, cursor_reg >= win_start && cursor_reg <= win_end, "cursor outside window")
    `TWC_ASSERT_NOW(a_single_writer, !(pend_valid_reg && dir_we), "two writes on one memory port")
    `TWC_ASSERT_IMP(a_done_source, done_reg, $past(state_reg == ST_EXEC || state_reg == ST_CLEAR), "done without finishing state")
    `TWC_ASSERT_NXT(a_accept_busy, start && !busy, busy, "request accepted but block not busy")

endmodule

@@ tb/sv/tb_top.sv @@
// self-checking testbench for the text window console: directed and random requests
module tb_top;

    localparam int ROWS  = 25;
    localparam int COLS  = 80;
    localparam int CELLS = ROWS * COLS;
    localparam int REQ_W = $bits(twc_pkg::req_t);
    localparam int RW    = twc_pkg::ROW_CFG_W;

    class screen_scoreboard;
        logic [7:0]          char_mem [CELLS];
        logic [7:0]          attr_mem [CELLS];
        int unsigned         cursor;
        logic [RW-1:0]       first_row;
        logic [RW-1:0]       last_row;
        logic [7:0]          ink_color;
        twc_pkg::rsp_t       predicted_rsp [$];
        int unsigned         mismatch_count;

        function new();
            for (int i = 0; i < CELLS; i++)
            begin
                char_mem[i] = twc_pkg::BLANK_CHAR;
                attr_mem[i] = twc_pkg::ATTR_RESET;
            end
            first_row      = twc_pkg::FIRST_ROW_RESET;
            last_row       = twc_pkg::LAST_ROW_RESET;
            ink_color      = twc_pkg::INK_COLOR_RESET;
            mismatch_count = 0;
            cursor         = window_start();
        endfunction

        function int unsigned window_start();
            int unsigned top;
            top = (int'(first_row) > ROWS - 1) ? ROWS - 1 : int'(first_row);
            return top * COLS;
        endfunction

        function int unsigned window_end();
            int unsigned top;
            int unsigned bottom;
            top    = (int'(first_row) > ROWS - 1) ? ROWS - 1 : int'(first_row);
            bottom = (int'(last_row) > ROWS - 1) ? ROWS - 1 : int'(last_row);
            if (bottom < top)
                bottom = top;
            return (bottom + 1) * COLS;
        endfunction

        function void scroll_up(int unsigned lo, int unsigned hi);
            for (int unsigned i = lo; i < hi - COLS; i++)
            begin
                char_mem[i] = char_mem[i + COLS];
                attr_mem[i] = ink_color;
            end
            for (int unsigned i = hi - COLS; i < hi; i++)
                char_mem[i] = twc_pkg::BLANK_CHAR;
            cursor = (cursor >= COLS) ? cursor - COLS : 0;
            if (cursor < lo)
                cursor = lo;
        endfunction

        function void set_register(twc_pkg::reg_index_t idx, logic [31:0] value);
            case (idx)
                twc_pkg::REG_FIRST_ROW:
                begin
                    first_row = value[RW-1:0];
                    cursor    = window_start();
                end
                twc_pkg::REG_LAST_ROW:
                begin
                    last_row = value[RW-1:0];
                    cursor   = window_start();
                end
                twc_pkg::REG_INK_COLOR:
                    ink_color = value[7:0];
                default:
                    ;
            endcase
        endfunction

        function void note_request(twc_pkg::req_t r);
            int unsigned   lo;
            int unsigned   hi;
            int unsigned   idx;
            twc_pkg::rsp_t predicted;
            lo        = window_start();
            hi        = window_end();
            predicted = '0;
            if (cursor < lo)
                cursor = lo;
            if (cursor > hi)
                cursor = hi;
            case (r.opcode)
                twc_pkg::OP_PUT:
                begin
                    if (r.char_code == twc_pkg::NEWLINE_CHAR)
                    begin
                        if (cursor == hi)
                            scroll_up(lo, hi);
                        cursor += COLS - ((cursor - lo) % COLS);
                        if (cursor > hi)
                            cursor = hi;
                    end
                    else
                    begin
                        if (cursor >= hi)
                            scroll_up(lo, hi);
                        char_mem[cursor] = r.char_code;
                        attr_mem[cursor] = ink_color;
                        cursor++;
                    end
                end
                twc_pkg::OP_BACKSPACE:
                begin
                    if (cursor != lo)
                    begin
                        cursor--;
                        char_mem[cursor] = twc_pkg::BLANK_CHAR;
                    end
                end
                twc_pkg::OP_CLEAR:
                begin
                    for (int unsigned i = lo; i < hi; i++)
                    begin
                        char_mem[i] = twc_pkg::BLANK_CHAR;
                        attr_mem[i] = ink_color;
                    end
                    cursor = lo;
                end
                twc_pkg::OP_READ:
                begin
                    if (r.cell_row < ROWS && r.cell_col < COLS)
                    begin
                        idx                 = int'(r.cell_row) * COLS + int'(r.cell_col);
                        predicted.cell_char = char_mem[idx];
                        predicted.cell_attr = attr_mem[idx];
                    end
                end
                default:
                    ;
            endcase
            predicted.cursor_offset = twc_pkg::offset_t'(cursor);
            predicted_rsp.push_back(predicted);
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            mismatch_count++;
        endtask

        task check_rsp(twc_pkg::rsp_t got);
            twc_pkg::rsp_t want;
            if (predicted_rsp.size() == 0)
            begin
                report_mismatch($sformatf("response %h with no request outstanding", got));
                return;
            end
            want = predicted_rsp.pop_front();
            if (got.cursor_offset !== want.cursor_offset)
                report_mismatch($sformatf("cursor_offset %0d, want %0d",
                                          got.cursor_offset, want.cursor_offset));
            if (got.cell_char !== want.cell_char)
                report_mismatch($sformatf("cell_char %h, want %h",
                                          got.cell_char, want.cell_char));
            if (got.cell_attr !== want.cell_attr)
                report_mismatch($sformatf("cell_attr %h, want %h",
                                          got.cell_attr, want.cell_attr));
        endtask
    endclass

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         start = 1'b0;
    twc_pkg::req_t                req = '0;
    logic                         busy;
    logic                         done;
    twc_pkg::rsp_t                rsp;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [twc_pkg::PADDR_W-1:0]  paddr = '0;
    logic [31:0]                  pwdata = '0;
    logic [31:0]                  prdata;
    logic                         pready;

    screen_scoreboard sb = new();
    int unsigned      idle_pct = 0;
    int unsigned      win_top = 0;
    int unsigned      win_bottom = ROWS - 1;

    text_window_console u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .req     (req),
        .busy    (busy),
        .done    (done),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sb.note_request(req);
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_rsp(rsp);
    end

    function automatic twc_pkg::req_t make_req(twc_pkg::opcode_t op, logic [7:0] ch,
                                               logic [RW-1:0] row, logic [6:0] col);
        twc_pkg::req_t r;
        r.opcode    = op;
        r.char_code = ch;
        r.cell_row  = row;
        r.cell_col  = col;
        return r;
    endfunction

    // mostly puts, reads biased into the window
    function automatic twc_pkg::req_t random_request();
        twc_pkg::req_t r;
        int unsigned   pick;
        r    = twc_pkg::req_t'(REQ_W'($urandom));
        pick = $urandom_range(99, 0);
        if (pick < 62)
        begin
            r.opcode = twc_pkg::OP_PUT;
            if ($urandom_range(99, 0) < 15)
                r.char_code = twc_pkg::NEWLINE_CHAR;
        end
        else if (pick < 72)
            r.opcode = twc_pkg::OP_BACKSPACE;
        else if (pick < 75)
            r.opcode = twc_pkg::OP_CLEAR;
        else
        begin
            r.opcode = twc_pkg::OP_READ;
            if ($urandom_range(99, 0) < 80)
            begin
                r.cell_row = RW'($urandom_range(win_bottom, win_top));
                r.cell_col = 7'($urandom_range(COLS - 1, 0));
            end
        end
        return r;
    endfunction

    task automatic send_request(input twc_pkg::req_t r);
        start = 1'b1;
        req   = r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        while ($urandom_range(99, 0) < idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
    endtask

    task automatic write_register(input twc_pkg::reg_index_t idx, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_register(idx, value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic wait_idle();
        start = 1'b0;
        while (sb.predicted_rsp.size() != 0 || busy)
            @(negedge clk);
    endtask

    task automatic set_window(input logic [RW-1:0] top, input logic [RW-1:0] bottom,
                              input logic [7:0] color);
        wait_idle();
        write_register(twc_pkg::REG_FIRST_ROW, 32'(top));
        write_register(twc_pkg::REG_LAST_ROW, 32'(bottom));
        write_register(twc_pkg::REG_INK_COLOR, 32'(color));
        win_top    = sb.window_start() / COLS;
        win_bottom = sb.window_end() / COLS - 1;
    endtask

    initial
    begin
        logic [RW-1:0] top;
        logic [RW-1:0] bottom;
        logic [7:0]    color;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        wait_idle();

        // full screen window at reset settings
        send_request(make_req(twc_pkg::OP_READ, 8'h00, 5'd0, 7'd0));
        send_request(make_req(twc_pkg::OP_READ, 8'h00, 5'd24, 7'd79));
        send_request(make_req(twc_pkg::OP_READ, 8'h00, 5'd25, 7'd0));
        send_request(make_req(twc_pkg::OP_READ, 8'h00, 5'd0, 7'd80));
        send_request(make_req(twc_pkg::OP_READ, 8'hFF, 5'd31, 7'd127));
        send_request(make_req(twc_pkg::OP_BACKSPACE, 8'h00, 5'd0, 7'd0));
        send_request(make_req(twc_pkg::OP_PUT, 8'h00, 5'd0, 7'd0));
        send_request(make_req(twc_pkg::OP_PUT, 8'hFF, 5'd31, 7'd127));
        send_request(make_req(twc_pkg::OP_PUT, 8'h41, 5'd0, 7'd0));
        send_request(make_req(twc_pkg::OP_BACKSPACE, 8'h00, 5'd0, 7'd0));
        send_request(make_req(twc_pkg::OP_PUT, twc_pkg::NEWLINE_CHAR, 5'd0, 7'd0));
        send_request(make_req(twc_pkg::OP_READ, 8'h00, 5'd0, 7'd0));
        send_request(make_req(twc_pkg::OP_READ, 8'h00, 5'd0, 7'd1));
        send_request(make_req(twc_pkg::OP_CLEAR, 8'h00, 5'd0, 7'd0));
        send_request(make_req(twc_pkg::OP_READ, 8'h00, 5'd0, 7'd0));

        // one-row window on the bottom row: newline to the end, then scrolls
        set_window(5'd24, 5'd24, 8'hA5);
        send_request(make_req(twc_pkg::OP_PUT, 8'h51, 5'd0, 7'd0));
        send_request(make_req(twc_pkg::OP_PUT, twc_pkg::NEWLINE_CHAR, 5'd0, 7'd0));
        send_request(make_req(twc_pkg::OP_PUT, twc_pkg::NEWLINE_CHAR, 5'd0, 7'd0));
        send_request(make_req(twc_pkg::OP_PUT, 8'h5A, 5'd0, 7'd0));
        send_request(make_req(twc_pkg::OP_READ, 8'h00, 5'd24, 7'd0));
        send_request(make_req(twc_pkg::OP_READ, 8'h00, 5'd23, 7'd79));
        send_request(make_req(twc_pkg::OP_BACKSPACE, 8'h00, 5'd0, 7'd0));

        for (int p = 0; p < 9; p++)
        begin
            color  = 8'($urandom_range(255, 0));
            top    = RW'($urandom_range(31, 0));
            bottom = (top > 28) ? 5'd31 : top + 5'($urandom_range(3, 0));
            case (p)
                0:
                begin
                    top    = 5'd0;
                    bottom = 5'd24;
                    color  = 8'hFF;
                end
                1:
                begin
                    top    = 5'd24;
                    bottom = 5'd31;
                    color  = 8'h00;
                end
                2:
                begin
                    top    = 5'd12;
                    bottom = 5'd3;
                end
                3:
                begin
                    top    = 5'd31;
                    bottom = 5'd0;
                end
                4:
                begin
                    top    = 5'd0;
                    bottom = 5'd0;
                end
                default:
                    ;
            endcase
            set_window(top, bottom, color);
            idle_pct = (p < 3) ? 18 : (p < 6) ? 54 : 0;
            for (int n = 0; n < 117; n++)
                send_request(random_request());
        end

        wait_idle();
        repeat (8) @(negedge clk);
        if (sb.mismatch_count == 0)
            $display("text_window_console test passed");
        else
            $display("text_window_console test failed");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("text_window_console test failed");
        $finish;
    end

endmodule
